[sv/plm_pkg.sv]
// Shared types and constants for the processing load meter.
`timescale 1ns / 1ps
`default_nettype none
package plm_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned WgtW   = 17;
  localparam int unsigned PctW   = 55;
  localparam int unsigned ProdW  = 64;
  localparam int unsigned AvgW   = 49;
  localparam int unsigned StepW  = 6;
  localparam int unsigned OutCntW = 48;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned RecipW = 33;
  localparam int unsigned RecipShift = 30;

  localparam logic [CfgIdxW-1:0] RegEnable   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWindow   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFallRate = 2'd2;

  localparam logic [DataW-1:0] WindowReset   = 32'd500000000;
  localparam logic [DataW-1:0] FallRateReset = 32'd3276800;

  localparam logic [DataW-1:0] PctScale  = 32'd6553600;
  localparam logic [DataW-1:0] OverLimit = 32'd6553600;
  localparam logic [DataW-1:0] NsPerSec  = 32'd1000000000;
  localparam logic [DataW-1:0] NsPerSec2 = 32'd2000000000;
  localparam logic [DataW-1:0] NsPerSec3 = 32'd3000000000;
  localparam logic [RecipW-1:0] FallRecip = 33'd4611686018;
  localparam logic [WgtW-1:0]  QOne      = 17'h10000;
  localparam logic [DataW-1:0] PctSat    = 32'hFFFFFFFF;

  localparam logic [StepW-1:0] StepsFull = 6'd32;
  localparam logic [StepW-1:0] StepsHalf = 6'd16;

  typedef enum logic [1:0] {
    DIV_P,
    DIV_W,
    DIV_F
  } div_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     load_mul;
    logic     div_start;
    logic     cap;
    logic     cap_sat;
    div_sel_e sel;
    logic     recip_mul;
    logic     back_mul;
    logic     load_avg;
    logic     commit;
    logic     load_out;
  } plm_cmd_t;

  typedef struct packed {
    logic run_ok;
    logic p_sat;
    logic w_full;
    logic f_sat;
    logic div_done;
  } plm_sts_t;

endpackage
`default_nettype wire

[sv/plm_divider.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module plm_divider (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [plm_pkg::DataW-1:0]  rem_i,
  input  wire logic [plm_pkg::DataW-1:0]  lo_i,
  input  wire logic [plm_pkg::DataW-1:0]  divisor_i,
  input  wire logic [plm_pkg::StepW-1:0]  steps_i,
  output logic      [plm_pkg::DataW-1:0]  quo_o,
  output logic                            done_o
);
  import plm_pkg::*;

  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] lo_q, lo_d;
  logic [DataW-1:0] div_q, div_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;
  logic             fits;

  always_comb begin
    trial  = {rem_q, lo_q[DataW-1]};
    diff   = trial - {1'b0, div_q};
    fits   = trial >= {1'b0, div_q};
    rem_d  = rem_q;
    lo_d   = lo_q;
    div_d  = div_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = rem_i;
      lo_d   = lo_i;
      div_d  = divisor_i;
      quo_d  = '0;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DataW-1:0] : trial[DataW-1:0];
      lo_d  = {lo_q[DataW-2:0], 1'b0};
      quo_d = {quo_q[DataW-2:0], fits};
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

[sv/plm_datapath.sv]
// Load meter datapath: registers, multipliers, shared divider and state update.
`timescale 1ns / 1ps
`default_nettype none
module plm_datapath #(
  parameter int unsigned CountBits = 48
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire plm_pkg::plm_cmd_t             cmd_i,
  output plm_pkg::plm_sts_t                  sts_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [plm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [plm_pkg::DataW-1:0]     cfg_data_i,
  input  wire logic [plm_pkg::DataW-1:0]     elapsed_ns_i,
  input  wire logic [plm_pkg::DataW-1:0]     buffer_ns_i,
  output logic      [plm_pkg::DataW-1:0]     load_percent_o,
  output logic      [plm_pkg::DataW-1:0]     peak_percent_o,
  output logic      [plm_pkg::OutCntW-1:0]   overrun_total_o,
  output logic                               was_updated_o
);
  import plm_pkg::*;

  logic                 enable_q;
  logic [DataW-1:0]     window_q;
  logic [DataW-1:0]     rate_q;
  logic [DataW-1:0]     avg_q, avg_d;
  logic [DataW-1:0]     peak_q, peak_d;
  logic [CountBits-1:0] tally_q, tally_d;
  logic                 upd_q;

  logic [DataW-1:0]     el_q;
  logic [DataW-1:0]     buf_q;
  logic [PctW-1:0]      prod_p_q;
  logic [ProdW-1:0]     prod_f_q;
  logic [DataW-1:0]     p_q;
  logic [WgtW-1:0]      w_q;
  logic [DataW-1:0]     f_q;
  logic [AvgW-1:0]      prod_a_q;
  logic                 a_up_q;
  logic [DataW-1:0]     fq0_q;
  logic [ProdW-1:0]     fback_q;

  logic [DataW-1:0]     load_q;
  logic [DataW-1:0]     peak_out_q;
  logic [OutCntW-1:0]   total_q;
  logic                 upd_out_q;

  logic [DataW-1:0]     div_rem;
  logic [DataW-1:0]     div_lo;
  logic [DataW-1:0]     div_den;
  logic [StepW-1:0]     div_steps;
  logic [DataW-1:0]     quo;
  logic                 div_done;

  logic [ProdW-1:0]     recip_prod;
  logic [ProdW-1:0]     f_rem;
  logic [1:0]           f_fix;
  logic [DataW-1:0]     f_quo;

  logic [DataW-1:0]     diff;
  logic                 a_up;
  logic [AvgW-17:0]     inc;
  logic [DataW-1:0]     decayed;

  always_comb begin
    unique case (cmd_i.sel)
      DIV_P: begin
        div_rem   = DataW'(prod_p_q[PctW-1:DataW]);
        div_lo    = prod_p_q[DataW-1:0];
        div_den   = buf_q;
        div_steps = StepsFull;
      end
      DIV_W: begin
        div_rem   = buf_q;
        div_lo    = '0;
        div_den   = window_q;
        div_steps = StepsHalf;
      end
      default: begin
        div_rem   = '0;
        div_lo    = '0;
        div_den   = '1;
        div_steps = StepsFull;
      end
    endcase
  end

  plm_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .rem_i     (div_rem),
    .lo_i      (div_lo),
    .divisor_i (div_den),
    .steps_i   (div_steps),
    .quo_o     (quo),
    .done_o    (div_done)
  );

  always_comb begin
    sts_o.run_ok   = enable_q && (buf_q != '0);
    sts_o.p_sat    = DataW'(prod_p_q[PctW-1:DataW]) >= buf_q;
    sts_o.w_full   = buf_q >= window_q;
    sts_o.f_sat    = prod_f_q[ProdW-1:DataW] >= NsPerSec;
    sts_o.div_done = div_done;
  end

  // Estimate the peak fall from a reciprocal, then correct by up to three.
  always_comb begin
    recip_prod = ProdW'(prod_f_q[RecipShift+DataW-1:RecipShift]) * ProdW'(FallRecip);
    f_rem      = prod_f_q - fback_q;
    f_fix      = 2'd0;
    if (f_rem >= ProdW'(NsPerSec)) begin
      f_fix = 2'd1;
    end
    if (f_rem >= ProdW'(NsPerSec2)) begin
      f_fix = 2'd2;
    end
    if (f_rem >= ProdW'(NsPerSec3)) begin
      f_fix = 2'd3;
    end
    f_quo = fq0_q + DataW'(f_fix);
  end

  always_comb begin
    a_up    = p_q >= avg_q;
    diff    = a_up ? (p_q - avg_q) : (avg_q - p_q);
    inc     = prod_a_q[AvgW-1:16];
    avg_d   = a_up_q ? (avg_q + inc[DataW-1:0]) : (avg_q - inc[DataW-1:0]);
    decayed = (peak_q > f_q) ? (peak_q - f_q) : '0;
    peak_d  = (p_q > decayed) ? p_q : decayed;
    tally_d = tally_q;
    if ((p_q > OverLimit) && (tally_q != {CountBits{1'b1}})) begin
      tally_d = tally_q + CountBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      window_q <= WindowReset;
      rate_q   <= FallRateReset;
      avg_q    <= '0;
      peak_q   <= '0;
      tally_q  <= '0;
      upd_q    <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        upd_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        avg_q   <= avg_d;
        peak_q  <= peak_d;
        tally_q <= tally_d;
        upd_q   <= 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegEnable: begin
            enable_q <= cfg_data_i[0];
            if (!cfg_data_i[0]) begin
              avg_q   <= '0;
              peak_q  <= '0;
              tally_q <= '0;
            end
          end
          RegWindow:   window_q <= cfg_data_i;
          RegFallRate: rate_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      el_q  <= elapsed_ns_i;
      buf_q <= buffer_ns_i;
    end
    if (cmd_i.load_mul) begin
      prod_p_q <= PctW'(el_q) * PctW'(PctScale);
      prod_f_q <= ProdW'(rate_q) * ProdW'(buf_q);
    end
    if (cmd_i.recip_mul) begin
      fq0_q <= recip_prod[2*DataW-1:DataW];
    end
    if (cmd_i.back_mul) begin
      fback_q <= ProdW'(fq0_q) * ProdW'(NsPerSec);
    end
    if (cmd_i.cap) begin
      unique case (cmd_i.sel)
        DIV_P:   p_q <= cmd_i.cap_sat ? PctSat : quo;
        DIV_W:   w_q <= cmd_i.cap_sat ? QOne : {1'b0, quo[WgtW-2:0]};
        DIV_F:   f_q <= cmd_i.cap_sat ? PctSat : f_quo;
        default: ;
      endcase
    end
    if (cmd_i.load_avg) begin
      prod_a_q <= AvgW'(w_q) * AvgW'(diff);
      a_up_q   <= a_up;
    end
    if (cmd_i.load_out) begin
      load_q     <= avg_q;
      peak_out_q <= peak_q;
      total_q    <= OutCntW'(tally_q);
      upd_out_q  <= upd_q;
    end
  end

  assign load_percent_o  = load_q;
  assign peak_percent_o  = peak_out_q;
  assign overrun_total_o = total_q;
  assign was_updated_o   = upd_out_q;

endmodule
`default_nettype wire

[sv/plm_ctrl.sv]
// Load meter sequencer: steps one request through multiply, divide and update.
`timescale 1ns / 1ps
`default_nettype none
module plm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire plm_pkg::plm_sts_t  sts_i,
  output plm_pkg::plm_cmd_t       cmd_o
);
  import plm_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL     = 4'd1;
  localparam logic [3:0] S_P_START = 4'd2;
  localparam logic [3:0] S_P_RUN   = 4'd3;
  localparam logic [3:0] S_W_START = 4'd4;
  localparam logic [3:0] S_W_RUN   = 4'd5;
  localparam logic [3:0] S_F_START = 4'd6;
  localparam logic [3:0] S_F_RUN   = 4'd7;
  localparam logic [3:0] S_F_MUL   = 4'd8;
  localparam logic [3:0] S_AVG     = 4'd9;
  localparam logic [3:0] S_COMMIT  = 4'd10;
  localparam logic [3:0] S_PUSH    = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.sel   = DIV_P;
    slot_free   = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.load_mul = 1'b1;
        state_d        = sts_i.run_ok ? S_P_START : S_PUSH;
      end
      S_P_START: begin
        cmd_o.sel = DIV_P;
        if (sts_i.p_sat) begin
          cmd_o.cap     = 1'b1;
          cmd_o.cap_sat = 1'b1;
          state_d       = S_W_START;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_P_RUN;
        end
      end
      S_P_RUN: begin
        cmd_o.sel = DIV_P;
        if (sts_i.div_done) begin
          cmd_o.cap = 1'b1;
          state_d   = S_W_START;
        end
      end
      S_W_START: begin
        cmd_o.sel = DIV_W;
        if (sts_i.w_full) begin
          cmd_o.cap     = 1'b1;
          cmd_o.cap_sat = 1'b1;
          state_d       = S_F_START;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_W_RUN;
        end
      end
      S_W_RUN: begin
        cmd_o.sel = DIV_W;
        if (sts_i.div_done) begin
          cmd_o.cap = 1'b1;
          state_d   = S_F_START;
        end
      end
      S_F_START: begin
        cmd_o.sel = DIV_F;
        if (sts_i.f_sat) begin
          cmd_o.cap     = 1'b1;
          cmd_o.cap_sat = 1'b1;
          state_d       = S_AVG;
        end else begin
          cmd_o.recip_mul = 1'b1;
          state_d         = S_F_MUL;
        end
      end
      S_F_MUL: begin
        cmd_o.sel      = DIV_F;
        cmd_o.back_mul = 1'b1;
        state_d        = S_F_RUN;
      end
      S_F_RUN: begin
        cmd_o.sel = DIV_F;
        cmd_o.cap = 1'b1;
        state_d   = S_AVG;
      end
      S_AVG: begin
        cmd_o.load_avg = 1'b1;
        state_d        = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_PUSH;
      end
      S_PUSH: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[sv/processing_load_meter.sv]
// Processing load meter top level: smoothed load, decaying peak and overrun count.
`timescale 1ns / 1ps
`default_nettype none
// Each request reports one processed audio block (elapsed and buffer time in ns) and
// returns one result with the smoothed load, the decaying peak, the overrun count
// and whether the request updated the meter. One request is in work at a time; a
// finished result waits in the output register while the next request is taken.
// A result may wait for the output register to free. For a request that updates
// the meter, one shared bit-serial divider works out the instant load (32 steps)
// and the averaging weight (16 steps) in turn, the peak fall comes from a
// reciprocal multiplication with a small correction of up to three, and each
// quotient that would overflow is saturated instead. A request that is ignored
// (meter disabled or zero buffer) goes from the multiply step straight to its result.
module processing_load_meter #(
  parameter int unsigned CountBits = 48
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [plm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [plm_pkg::DataW-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [plm_pkg::DataW-1:0]     elapsed_ns_i,
  input  wire logic [plm_pkg::DataW-1:0]     buffer_ns_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [plm_pkg::DataW-1:0]     load_percent_o,
  output logic      [plm_pkg::DataW-1:0]     peak_percent_o,
  output logic      [plm_pkg::OutCntW-1:0]   overrun_total_o,
  output logic                               was_updated_o
);
  import plm_pkg::*;

  plm_cmd_t cmd;
  plm_sts_t sts;

  plm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  plm_datapath #(
    .CountBits (CountBits)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .elapsed_ns_i    (elapsed_ns_i),
    .buffer_ns_i     (buffer_ns_i),
    .load_percent_o  (load_percent_o),
    .peak_percent_o  (peak_percent_o),
    .overrun_total_o (overrun_total_o),
    .was_updated_o   (was_updated_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready still high after request accepted");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a request in work");

  a_div_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_done |-> !in_ready_o)
    else $error("divider finished while idle");

  a_div_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !sts.div_done)
    else $error("divider finished one cycle after start");

endmodule
`default_nettype wire
